### design/cbmc_pkg.sv
package cbmc_pkg;

    localparam int DEBOUNCE_W   = 10;
    localparam int LONG_PRESS_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RESET   = 10'd50;
    localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = 12'd1000;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 1'b1;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [2:0] {
        MODE_SHOW = 3'd0,
        MODE_MIN  = 3'd1,
        MODE_HOUR = 3'd2,
        MODE_FMT  = 3'd3,
        MODE_AMPM = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    localparam logic [2:0] ACT_NONE = 3'd0;

    typedef struct packed {
        logic [2:0] down_action;
        logic [2:0] up_action;
        logic [1:0] mode_event;
        logic [2:0] mode_state;
    } result_t;

endpackage

### design/cbmc_core.sv
module cbmc_core
    import cbmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   tick,
    input  logic                   mode_level,
    input  logic                   up_level,
    input  logic                   down_level,
    input  logic                   twelve_hour,
    output result_t                result
);

    localparam int DB_CMP_W = (COUNT_WIDTH > DEBOUNCE_W) ? COUNT_WIDTH : DEBOUNCE_W;
    localparam int LP_CMP_W = (COUNT_WIDTH > LONG_PRESS_W) ? COUNT_WIDTH : LONG_PRESS_W;

    logic [DEBOUNCE_W-1:0]   debounce_reg;
    logic [LONG_PRESS_W-1:0] long_press_reg;

    logic [2:0]             mode_reg, mode_next;
    logic [2:0]             prev_reg;
    logic [COUNT_WIDTH-1:0] since_reg [3];
    logic [COUNT_WIDTH-1:0] since_next [3];
    logic [COUNT_WIDTH-1:0] since_inc [3];
    logic [COUNT_WIDTH-1:0] timer_reg, timer_next, timer_inc;
    logic                   timing_reg, timing_next;

    logic [2:0] levels;
    logic [2:0] accepted;
    logic [1:0] ev;
    logic [2:0] action;

    assign levels = {down_level, up_level, mode_level};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            since_inc[i] = (&since_reg[i]) ? since_reg[i] : since_reg[i] + 1'b1;
            accepted[i]  = (levels[i] != prev_reg[i]) &&
                           (DB_CMP_W'(since_inc[i]) > DB_CMP_W'(debounce_reg));
        end
        timer_inc = (&timer_reg) ? timer_reg : timer_reg + 1'b1;
    end

    always_comb begin
        mode_next   = mode_reg;
        timer_next  = timer_reg;
        timing_next = timing_reg;
        ev          = EV_NONE;
        for (int i = 0; i < 3; i++) begin
            since_next[i] = since_inc[i];
        end

        if (timing_reg) begin
            timer_next = timer_inc;
            if (!mode_level) begin
                ev = EV_SHORT;
                case (mode_reg)
                    MODE_MIN:  mode_next = MODE_HOUR;
                    MODE_HOUR: mode_next = MODE_FMT;
                    MODE_FMT:  mode_next = twelve_hour ? MODE_AMPM : MODE_MIN;
                    MODE_AMPM: mode_next = MODE_MIN;
                    default:   mode_next = mode_reg;
                endcase
            end else if (LP_CMP_W'(timer_inc) >= LP_CMP_W'(long_press_reg)) begin
                ev        = EV_LONG;
                mode_next = (mode_reg == MODE_SHOW) ? MODE_MIN : MODE_SHOW;
            end
            if (ev != EV_NONE) begin
                timing_next   = 1'b0;
                since_next[0] = '0;
            end
        end else begin
            if (accepted[0]) begin
                since_next[0] = '0;
                if (mode_level) begin
                    timing_next = 1'b1;
                    timer_next  = '0;
                end
            end
            for (int i = 1; i < 3; i++) begin
                if (accepted[i]) begin
                    since_next[i] = '0;
                end
            end
        end
    end

    // action code equals the setting state; none in show time or unused codes
    assign action = (mode_next >= MODE_MIN && mode_next <= MODE_AMPM) ? mode_next : ACT_NONE;

    always_comb begin
        result.mode_state  = mode_next;
        result.mode_event  = ev;
        result.up_action   = (!timing_reg && accepted[1] && up_level) ? action : ACT_NONE;
        result.down_action = (!timing_reg && accepted[2] && down_level) ? action : ACT_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data[DEBOUNCE_W-1:0];
                REG_LONG_PRESS: long_press_reg <= cfg_data[LONG_PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SHOW;
            prev_reg   <= '0;
            timer_reg  <= '0;
            timing_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                since_reg[i] <= '0;
            end
        end else if (tick) begin
            mode_reg   <= mode_next;
            prev_reg   <= levels;
            timer_reg  <= timer_next;
            timing_reg <= timing_next;
            for (int i = 0; i < 3; i++) begin
                since_reg[i] <= since_next[i];
            end
        end
    end

endmodule

### design/clock_button_mode_controller_top.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tdata: tick button levels and hour format
// m_        out  m_tvalid/m_tready  m_tdata: mode state, mode event, up/down actions
// cfg_      in   cfg_wr_en          cfg_index, cfg_data
//
// One word in, one word out; a word is taken every cycle while downstream keeps up.
// The result of a taken word is registered in the output register before it appears on m_.
// A word taken while m_tvalid is high and m_tready is low waits in a skid register; s_tready is low while it is full.
// Reset is synchronous on aresetn; registers return to 50 and 1000 ticks.
module clock_button_mode_controller_top
    import cbmc_pkg::*;
#(
    parameter int COUNT_WIDTH = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // mode_level, up_level, down_level, twelve_hour, zero pad
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mode_state[2:0], mode_event[4:3], up_action[7:5], down_action[10:8], zero pad
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    result_t result;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    take, pop;

    assign s_tready = !skid_valid_reg;
    assign take     = s_tvalid && s_tready;
    assign pop      = out_valid_reg && m_tready;

    cbmc_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .tick        (take),
        .mode_level  (s_tdata[0]),
        .up_level    (s_tdata[1]),
        .down_level  (s_tdata[2]),
        .twelve_hour (s_tdata[3]),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= take;
            end
        end else if (take) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end else if (take) begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_reg);

endmodule

### test/tb_top.sv
module tb_top;
    import cbmc_pkg::*;

    localparam int CNT_W = 12;
    localparam logic [CNT_W-1:0] CNT_TOP = '1;
    localparam int N_ROWS = 26;
    localparam int N_PHASES = 8;

    localparam result_t SHOW_IDLE = '{
        down_action: ACT_NONE, up_action: ACT_NONE, mode_event: EV_NONE, mode_state: MODE_SHOW
    };

    // levels are {twelve_hour, down, up, mode}; typed rows carry their own expected word
    typedef struct packed {
        logic [3:0] lv;
        logic       typed;
        result_t    res;
    } tick_row_t;

    localparam tick_row_t [0:N_ROWS-1] DIRECTED = {
        {4'b1111, 1'b1, SHOW_IDLE},   // reset registers: nothing debounced yet
        {4'b0000, 1'b1, SHOW_IDLE},
        {4'b0010, 1'b1, SHOW_IDLE},   // up in show time gives no action
        {4'b0101, 1'b0, SHOW_IDLE},
        {4'b0011, 1'b0, SHOW_IDLE},   // up ignored while the press is timed
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0101, 1'b0, SHOW_IDLE},   // long press: enter setting
        {4'b0000, 1'b0, SHOW_IDLE},
        {4'b0010, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0000, 1'b0, SHOW_IDLE},
        {4'b0110, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b1000, 1'b0, SHOW_IDLE},
        {4'b1001, 1'b0, SHOW_IDLE},
        {4'b1000, 1'b0, SHOW_IDLE},   // format -> AM/PM in 12-hour mode
        {4'b1100, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0000, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},   // long press: leave setting
        {4'b0000, 1'b0, SHOW_IDLE},
        {4'b0001, 1'b0, SHOW_IDLE},
        {4'b0000, 1'b0, SHOW_IDLE}    // short press in show time
    };

    // debounce data carries junk in its upper bits once; the register keeps 10 bits
    localparam logic [0:N_PHASES-1][CFG_DATA_W-1:0] PH_DEBOUNCE = {
        12'd2, 12'd0, 12'hC05, 12'd3, 12'd0, 12'd30, 12'd1, 12'd12
    };
    localparam logic [0:N_PHASES-1][CFG_DATA_W-1:0] PH_LONG = {
        12'd1, 12'd0, 12'd12, 12'd40, 12'd3, 12'd8, 12'd100, 12'd60
    };
    localparam logic [0:N_PHASES-1][15:0] PH_TICKS = {
        16'd130, 16'd90, 16'd180, 16'd220, 16'd130, 16'd200, 16'd160, 16'd130
    };

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    clock_button_mode_controller_top #(
        .COUNT_WIDTH(CNT_W)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // predictor state
    logic [DEBOUNCE_W-1:0]   dbn_cfg = DEBOUNCE_RESET;
    logic [LONG_PRESS_W-1:0] long_cfg = LONG_PRESS_RESET;
    mode_t                   cur_mode = MODE_SHOW;
    logic [2:0]              prev_lv = '0;
    logic [CNT_W-1:0]        since_chg [3] = '{'0, '0, '0};
    logic [CNT_W-1:0]        hold_timer = '0;
    bit                      timing = 1'b0;

    result_t    mode_results_due [$];
    int         errors = 0;
    int         ticks_sent = 0;
    int         steady_s = 0;
    logic [3:0] lv_cur = '0;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
        return (v == CNT_TOP) ? v : v + 1'b1;
    endfunction

    function automatic bit clean_edge(int b, logic lvl);
        if (lvl != prev_lv[b] && since_chg[b] > dbn_cfg) begin
            since_chg[b] = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [2:0] action_of(mode_t m);
        return (m >= MODE_MIN && m <= MODE_AMPM) ? m : ACT_NONE;
    endfunction

    function automatic result_t step_clock_fsm(logic [3:0] lv);
        result_t r;
        bit      was;
        r = SHOW_IDLE;
        was = timing;
        for (int i = 0; i < 3; i++) since_chg[i] = bump(since_chg[i]);
        if (was) begin
            hold_timer = bump(hold_timer);
            if (!lv[0]) begin
                r.mode_event = EV_SHORT;
                case (cur_mode)
                    MODE_MIN:  cur_mode = MODE_HOUR;
                    MODE_HOUR: cur_mode = MODE_FMT;
                    MODE_FMT:  cur_mode = lv[3] ? MODE_AMPM : MODE_MIN;
                    MODE_AMPM: cur_mode = MODE_MIN;
                    default: ;
                endcase
            end else if (hold_timer >= long_cfg) begin
                r.mode_event = EV_LONG;
                cur_mode = (cur_mode == MODE_SHOW) ? MODE_MIN : MODE_SHOW;
            end
            if (r.mode_event != EV_NONE) begin
                timing = 1'b0;
                since_chg[0] = '0;
            end
        end else if (clean_edge(0, lv[0]) && lv[0]) begin
            timing = 1'b1;
            hold_timer = '0;
        end
        if (!was) begin
            if (clean_edge(1, lv[1]) && lv[1]) r.up_action = action_of(cur_mode);
            if (clean_edge(2, lv[2]) && lv[2]) r.down_action = action_of(cur_mode);
        end
        prev_lv = lv[2:0];
        r.mode_state = cur_mode;
        return r;
    endfunction

    function automatic int s_gap();
        int r;
        if (steady_s > 0) begin
            steady_s--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            steady_s = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic int hold_len();
        int r;
        int d;
        r = $urandom_range(0, 99);
        d = int'(dbn_cfg);
        if (r < 70) return d + 1 + $urandom_range(0, 2);
        if (r < 90) return $urandom_range(1, d + 1);
        return d + $urandom_range(3, 10);
    endfunction

    task automatic send_tick(input logic [3:0] lv, input bit typed, input result_t typed_res);
        int      gap;
        result_t guess;
        gap = s_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-4){1'b0}}, lv};
        do @(posedge aclk); while (!s_tready);
        guess = step_clock_fsm(lv);
        mode_results_due.push_back(typed ? typed_res : guess);
        ticks_sent++;
    endtask

    task automatic hold_ticks(input int n);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0) lv_cur[3] = ~lv_cur[3];
            send_tick(lv_cur, 1'b0, SHOW_IDLE);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (mode_results_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] dbn, input logic [CFG_DATA_W-1:0] lp);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= dbn;
        @(posedge aclk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data  <= lp;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dbn_cfg  = dbn[DEBOUNCE_W-1:0];
        long_cfg = lp[LONG_PRESS_W-1:0];
    endtask

    // one burst of button activity: a timed mode press, up/down work, or noise
    task automatic play_burst();
        int r;
        int len;
        int c;
        int lp;
        r  = $urandom_range(0, 99);
        lp = int'(long_cfg);
        if (r < 55) begin
            lv_cur[0] = 1'b0;
            repeat ($urandom_range(1, 3)) begin
                lv_cur[2:1] = 2'($urandom_range(0, 3));
                hold_ticks(hold_len());
            end
            lv_cur[0] = 1'b1;
            lv_cur[3] = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 1)) len = lp + 1 + $urandom_range(0, 2);
            else len = $urandom_range(1, (lp > 0) ? lp : 1);
            while (len > 0) begin
                c = $urandom_range(1, 4);
                if (c > len) c = len;
                lv_cur[2:1] = 2'($urandom_range(0, 3));
                hold_ticks(c);
                len -= c;
            end
        end else if (r < 85) begin
            repeat ($urandom_range(2, 6)) begin
                lv_cur[2:1] = 2'($urandom_range(0, 3));
                hold_ticks(hold_len());
            end
        end else begin
            repeat ($urandom_range(2, 8)) begin
                lv_cur = 4'($urandom_range(0, 15));
                hold_ticks(1);
            end
        end
    endtask

    initial begin
        int start_ticks;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_DEBOUNCE;
        cfg_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < N_ROWS; i++) begin
            if (i == 2) program_regs(12'd0, 12'd3);
            send_tick(DIRECTED[i].lv, DIRECTED[i].typed, DIRECTED[i].res);
        end
        lv_cur = DIRECTED[N_ROWS-1].lv;

        for (int p = 0; p < N_PHASES; p++) begin
            program_regs(PH_DEBOUNCE[p], PH_LONG[p]);
            start_ticks = ticks_sent;
            while (ticks_sent - start_ticks < PH_TICKS[p]) play_burst();
        end

        drain();
        if (errors == 0) begin
            $display("[clock_button_mode_controller_top] OK");
        end else begin
            $display("[clock_button_mode_controller_top] ERROR");
        end
        $finish;
    end

    initial begin
        int r;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(30, 120)) @(posedge aclk);
            end else if (r < 70) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
            end else if (r < 92) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b0;
                repeat ($urandom_range(4, 30)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (mode_results_due.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_tdata);
                errors++;
            end else begin
                want = mode_results_due.pop_front();
                if (got !== want) begin
                    $display({"%0t: mismatch state %0d/%0d event %0d/%0d",
                              " up %0d/%0d down %0d/%0d (exp/act)"},
                             $time, want.mode_state, got.mode_state,
                             want.mode_event, got.mode_event,
                             want.up_action, got.up_action,
                             want.down_action, got.down_action);
                    errors++;
                end
            end
        end
    end

    initial begin
        #200000000;
        $display("[clock_button_mode_controller_top] ERROR");
        $finish;
    end

endmodule

### clock_button_mode_controller_top.f
design/cbmc_pkg.sv
design/cbmc_core.sv
design/clock_button_mode_controller_top.sv
test/tb_top.sv
